FILE: sv/ofb_pkg.sv
package ofb_pkg;

  typedef enum logic [2:0] {
    OP_POINT   = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_FILL    = 3'd2,
    OP_APPEND  = 3'd3,
    OP_RESTART = 3'd4,
    OP_REFRESH = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_CLEAR,
    B_PT_WR,
    B_FILL_RD,
    B_FILL_WR,
    B_SCROLL,
    B_TAIL
  } b_state_e;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] BYTE_ONES     = 8'hff;
  localparam logic [7:0] BIT_TOP       = 8'h80;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic       pixel_on;
    logic [7:0] sample;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } out_t;

  // classified command held in the queue
  typedef struct packed {
    op_e        op;
    logic [7:0] x0;
    logic [7:0] x1;
    logic [7:0] y0;
    logic [7:0] y1;
    logic       on;
    logic       draw;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: sv/oled_page_framebuffer_engine.sv
// channel   | ports                                 | beat taken when
// ----------+---------------------------------------+----------------------------------
// command   | start_i, busy_o, in_i                 | start_i high and busy_o low
// result    | result_valid_o, result_o              | every cycle result_valid_o is high
//
// a refresh byte passes through the command queue and the output registers after its
// command beat; back-to-back refresh commands stream one byte per cycle, bounded by
// the single frame store read port; point and sample plot read a byte then write it,
// fill reads and writes each touched byte, clear sweeps the whole store, and a
// scrolling sample moves every column one lower and then writes the new last column
// after reset all COLUMNS*PAGES bytes of the store (1024 at the default size) are
// swept to zero with busy_o high; after the sweep busy_o rises only when the command
// queue is full; results cannot be held off
module oled_page_framebuffer_engine #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ofb_pkg::in_t  in_i,
  output logic          busy_o,
  output logic          result_valid_o,
  output ofb_pkg::out_t result_o
);
  import ofb_pkg::*;

  // four slots hide the multi-cycle operations from the command side
  localparam int unsigned QDEPTH = 4;

  logic    push;
  logic    pop;
  logic    init;
  cmd_t    push_cmd;
  cmd_t    head;
  q_stat_t q_stat;

  // front: decode, clip, drop commands that change nothing
  ofb_front #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_front (
    .start_i  (start_i),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .init_i   (init),
    .busy_o   (busy_o),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // queue between decode and execution
  ofb_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .pop_i  (pop),
    .data_o (head),
    .stat_o (q_stat)
  );

  // back: frame store, sequencer for fill, clear and scroll, refresh streamer
  ofb_back #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .q_stat_i       (q_stat),
    .pop_o          (pop),
    .init_o         (init),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

FILE: sv/ofb_front.sv
module ofb_front #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 8
) (
  input  logic             start_i,
  input  ofb_pkg::in_t     in_i,
  input  ofb_pkg::q_stat_t q_stat_i,
  input  logic             init_i,
  output logic             busy_o,
  output logic             push_o,
  output ofb_pkg::cmd_t    cmd_o
);
  import ofb_pkg::*;

  localparam int unsigned ROWS = PAGES * 8;

  logic       keep;
  logic [7:0] x1c;
  logic [7:0] y1c;

  assign busy_o = q_stat_i.full | init_i;
  assign x1c    = (in_i.x_end > COLUMNS - 1) ? 8'(COLUMNS - 1) : in_i.x_end;
  assign y1c    = (in_i.y_end > ROWS - 1) ? 8'(ROWS - 1) : in_i.y_end;

  always_comb begin
    keep       = 1'b0;
    cmd_o.op   = OP_RESTART;
    cmd_o.x0   = in_i.x_pos;
    cmd_o.x1   = x1c;
    cmd_o.y0   = in_i.y_pos;
    cmd_o.y1   = y1c;
    cmd_o.on   = in_i.pixel_on;
    cmd_o.draw = 1'b0;
    case (op_e'(in_i.opcode))
      OP_POINT: begin
        cmd_o.op = OP_POINT;
        keep     = (in_i.x_pos < COLUMNS) && (in_i.y_pos < ROWS);
      end
      OP_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        keep     = 1'b1;
      end
      OP_FILL: begin
        // an empty rectangle still restarts refresh
        keep = 1'b1;
        if ((in_i.x_pos <= x1c) && (in_i.y_pos <= y1c)) begin
          cmd_o.op = OP_FILL;
        end
      end
      OP_APPEND: begin
        cmd_o.op   = OP_APPEND;
        keep       = (in_i.sample <= ROWS);
        cmd_o.draw = (in_i.sample < ROWS);
        cmd_o.y0   = 8'(ROWS - 1) - in_i.sample;
      end
      OP_RESTART: begin
        keep = 1'b1;
      end
      OP_REFRESH: begin
        cmd_o.op = OP_REFRESH;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = start_i & ~busy_o & keep;

endmodule

FILE: sv/ofb_queue.sv
module ofb_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ofb_pkg::cmd_t    data_i,
  input  logic             pop_i,
  output ofb_pkg::cmd_t    data_o,
  output ofb_pkg::q_stat_t stat_o
);
  import ofb_pkg::*;

  localparam int unsigned PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNW = $clog2(DEPTH + 1);

  cmd_t           slot_q [DEPTH];
  logic [PTW-1:0] wr_q, wr_d;
  logic [PTW-1:0] rd_q, rd_d;
  logic [CNW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  assign data_o       = slot_q[rd_q];
  assign stat_o.full  = (cnt_q == CNW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

FILE: sv/ofb_back.sv
module ofb_back #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ofb_pkg::cmd_t    head_i,
  input  ofb_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  output logic             init_o,
  output logic             result_valid_o,
  output ofb_pkg::out_t    result_o
);
  import ofb_pkg::*;

  localparam int unsigned DEPTH = COLUMNS * PAGES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XW    = $clog2(COLUMNS);
  localparam int unsigned CW    = XW + 1;
  localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned KW    = $clog2(COLUMNS + 3);

  function automatic logic [PW-1:0] page_of(input logic [7:0] y);
    page_of = PW'(PAGES - 1) - PW'(y[7:3]);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [PW-1:0] p);
    addr_of = AW'(AW'(x) * AW'(PAGES) + AW'(p));
  endfunction

  function automatic logic [7:0] row_mask(input logic [7:0] y);
    row_mask = BIT_TOP >> y[2:0];
  endfunction

  // rows of the rectangle that fall in page p, as a byte mask
  function automatic logic [7:0] fill_mask(input logic [PW-1:0] p, input logic [7:0] y0,
                                           input logic [7:0] y1);
    logic [PW-1:0] band;
    logic [2:0]    lo;
    logic [2:0]    hi;
    band      = PW'(PAGES - 1) - p;
    lo        = (band == PW'(y0[7:3])) ? y0[2:0] : 3'd0;
    hi        = (band == PW'(y1[7:3])) ? y1[2:0] : 3'd7;
    fill_mask = (BYTE_ONES >> lo) & (BYTE_ONES << (3'd7 - hi));
  endfunction

  b_state_e       state_q, state_d;
  cmd_t           cmd_q, cmd_d;
  logic [AW-1:0]  cnt_q, cnt_d;
  logic [XW-1:0]  cx_q, cx_d;
  logic [PW-1:0]  cp_q, cp_d;
  logic [AW-1:0]  sc_q, sc_d;
  logic           wv_q, wv_d;
  logic [AW-1:0]  wa_q, wa_d;
  logic [PW-1:0]  tp_q, tp_d;
  logic [CW-1:0]  count_q, count_d;
  logic [PW-1:0]  rpage_q, rpage_d;
  logic [KW-1:0]  rk_q, rk_d;
  logic           out_v_q, out_v_d;
  logic           out_dat_q, out_dat_d;
  logic           out_last_q, out_last_d;
  logic [7:0]     out_cmd_q, out_cmd_d;

  logic [7:0]     mem_q [DEPTH];
  logic [7:0]     rdata_q;
  logic           re, we;
  logic [AW-1:0]  raddr, waddr;
  logic [7:0]     wdata;
  logic [7:0]     mask;

  logic           can_col;
  logic           fill_col_done;
  logic           fill_all_done;

  assign can_col       = (count_q < CW'(COLUMNS));
  assign fill_col_done = (cp_q == page_of(cmd_q.y0));
  assign fill_all_done = fill_col_done && (cx_q == XW'(cmd_q.x1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_INIT, B_CLEAR: begin
        if (cnt_q == AW'(DEPTH - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          case (head_i.op)
            OP_POINT:  state_d = B_PT_WR;
            OP_CLEAR:  state_d = B_CLEAR;
            OP_FILL:   state_d = B_FILL_RD;
            OP_APPEND: begin
              if (!can_col) begin
                state_d = B_SCROLL;
              end else if (head_i.draw) begin
                state_d = B_PT_WR;
              end
            end
            default:   state_d = B_IDLE;
          endcase
        end
      end
      B_PT_WR:   state_d = B_IDLE;
      B_FILL_RD: state_d = B_FILL_WR;
      B_FILL_WR: state_d = fill_all_done ? B_IDLE : B_FILL_RD;
      B_SCROLL: begin
        if (sc_q == AW'(DEPTH - 1)) begin
          state_d = B_TAIL;
        end
      end
      B_TAIL: begin
        if (!wv_q && (tp_q == PW'(PAGES - 1))) begin
          state_d = B_IDLE;
        end
      end
      default:   state_d = B_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_d      = cmd_q;
    cnt_d      = cnt_q;
    cx_d       = cx_q;
    cp_d       = cp_q;
    sc_d       = sc_q;
    wv_d       = 1'b0;
    wa_d       = wa_q;
    tp_d       = tp_q;
    count_d    = count_q;
    rpage_d    = rpage_q;
    rk_d       = rk_q;
    out_v_d    = 1'b0;
    out_dat_d  = 1'b0;
    out_last_d = 1'b0;
    out_cmd_d  = out_cmd_q;
    pop_o      = 1'b0;
    re         = 1'b0;
    raddr      = '0;
    we         = wv_q;
    waddr      = wa_q;
    wdata      = rdata_q;
    mask       = BYTE_ZERO;
    case (state_q)
      B_INIT, B_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = BYTE_ZERO;
        cnt_d = (cnt_q == AW'(DEPTH - 1)) ? '0 : cnt_q + 1'b1;
      end
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          case (head_i.op)
            OP_POINT: begin
              re    = 1'b1;
              raddr = addr_of(XW'(head_i.x0), page_of(head_i.y0));
            end
            OP_CLEAR: begin
              cnt_d = '0;
            end
            OP_FILL: begin
              rpage_d = '0;
              rk_d    = '0;
              cx_d    = XW'(head_i.x0);
              cp_d    = page_of(head_i.y1);
            end
            OP_APPEND: begin
              cmd_d.on = 1'b1;
              if (can_col) begin
                count_d  = count_q + 1'b1;
                cmd_d.x0 = 8'(count_q);
                re       = head_i.draw;
                raddr    = addr_of(XW'(count_q), page_of(head_i.y0));
              end else begin
                sc_d = AW'(PAGES);
              end
            end
            OP_RESTART: begin
              rpage_d = '0;
              rk_d    = '0;
            end
            OP_REFRESH: begin
              out_v_d    = 1'b1;
              out_last_d = (rpage_q == PW'(PAGES - 1)) && (rk_q == KW'(COLUMNS + 2));
              if (rk_q == KW'(0)) begin
                out_cmd_d = CMD_PAGE_BASE + 8'(rpage_q);
              end else if (rk_q == KW'(1)) begin
                out_cmd_d = CMD_COL_LO;
              end else if (rk_q == KW'(2)) begin
                out_cmd_d = CMD_COL_HI;
              end else begin
                out_dat_d = 1'b1;
                re        = 1'b1;
                raddr     = addr_of(XW'(rk_q - KW'(3)), rpage_q);
              end
              if (rk_q == KW'(COLUMNS + 2)) begin
                rk_d    = '0;
                rpage_d = (rpage_q == PW'(PAGES - 1)) ? '0 : rpage_q + 1'b1;
              end else begin
                rk_d = rk_q + 1'b1;
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      B_PT_WR: begin
        mask  = row_mask(cmd_q.y0);
        we    = 1'b1;
        waddr = addr_of(XW'(cmd_q.x0), page_of(cmd_q.y0));
        wdata = cmd_q.on ? (rdata_q | mask) : (rdata_q & ~mask);
      end
      B_FILL_RD: begin
        re    = 1'b1;
        raddr = addr_of(cx_q, cp_q);
      end
      B_FILL_WR: begin
        mask  = fill_mask(cp_q, cmd_q.y0, cmd_q.y1);
        we    = 1'b1;
        waddr = addr_of(cx_q, cp_q);
        wdata = cmd_q.on ? (rdata_q | mask) : (rdata_q & ~mask);
        if (fill_col_done) begin
          cp_d = page_of(cmd_q.y1);
          cx_d = cx_q + 1'b1;
        end else begin
          cp_d = cp_q + 1'b1;
        end
      end
      B_SCROLL: begin
        // read one column ahead, write it back one column lower next cycle
        re    = 1'b1;
        raddr = sc_q;
        wv_d  = 1'b1;
        wa_d  = sc_q - AW'(PAGES);
        sc_d  = sc_q + 1'b1;
        tp_d  = '0;
      end
      B_TAIL: begin
        if (!wv_q) begin
          we    = 1'b1;
          waddr = AW'(DEPTH - PAGES) + AW'(tp_q);
          wdata = (cmd_q.draw && (tp_q == page_of(cmd_q.y0))) ? row_mask(cmd_q.y0)
                                                               : BYTE_ZERO;
          tp_d  = tp_q + 1'b1;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_INIT;
      cnt_q      <= '0;
      wv_q       <= 1'b0;
      count_q    <= '0;
      rpage_q    <= '0;
      rk_q       <= '0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      wv_q       <= wv_d;
      count_q    <= count_d;
      rpage_q    <= rpage_d;
      rk_q       <= rk_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    cx_q       <= cx_d;
    cp_q       <= cp_d;
    sc_q       <= sc_d;
    wa_q       <= wa_d;
    tp_q       <= tp_d;
    out_dat_q  <= out_dat_d;
    out_last_q <= out_last_d;
    out_cmd_q  <= out_cmd_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign init_o            = (state_q == B_INIT);
  assign result_valid_o    = out_v_q;
  assign result_o.out_byte = out_dat_q ? rdata_q : out_cmd_q;
  assign result_o.is_data  = out_dat_q;
  assign result_o.last     = out_last_q;

endmodule

FILE: sv/ofb_checker.sv
module ofb_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          busy_i,
  input logic          result_valid_i,
  input ofb_pkg::out_t result_i
);
  import ofb_pkg::*;

  // the closing beat of a refresh is always display data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && result_i.last |-> result_i.is_data)
    else $error("last on a command byte");

  // command bytes are page select or column address only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && !result_i.is_data |->
      (result_i.out_byte[7:4] == CMD_PAGE_BASE[7:4]) ||
      (result_i.out_byte == CMD_COL_LO) || (result_i.out_byte == CMD_COL_HI))
    else $error("unexpected command byte");

  // a beat straight after the column high command carries data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && !result_i.is_data && (result_i.out_byte == CMD_COL_HI) |=>
      !result_valid_i || result_i.is_data)
    else $error("data did not follow column address");

  // a beat straight after the last one starts a new frame at page zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && result_i.last |=>
      !result_valid_i || (!result_i.is_data && (result_i.out_byte == CMD_PAGE_BASE)))
    else $error("refresh did not wrap to page zero");

  // store sweep holds commands off right after reset
  assert property (@(posedge clk_i) !rst_ni |=> busy_i)
    else $error("not busy after reset");

endmodule

bind oled_page_framebuffer_engine ofb_checker u_ofb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy_i         (busy_o),
  .result_valid_i (result_valid_o),
  .result_i       (result_o)
);
